// ===== rtl/spll_pkg.sv =====
// Shared constants, types, sine table and lookup function for the single-phase PLL.
package spll_pkg;

    // Window geometry; the window length is a power of two
    localparam int WINDOW_LEN    = 1024;
    localparam int WIN_SHIFT     = $clog2(WINDOW_LEN);

    // Sine table geometry
    localparam int SINE_ROM_BITS = 8;
    localparam int ROM_SIZE      = (1 << SINE_ROM_BITS) + 1;
    localparam int ROM_ADDR_W    = SINE_ROM_BITS + 1;

    // Datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = PROD_W + WIN_SHIFT;
    localparam int ERR_W      = PROD_W + 1;
    localparam int GAIN_W     = 16;
    localparam int MUL_A_W    = ERR_W;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int MUL_W      = MUL_A_W + MUL_B_W;
    localparam int STEP_W     = 32;
    localparam int STEP_EXT_W = STEP_W + 2;
    localparam int INTEG_SHIFT = 28;
    localparam int PROP_SHIFT  = 22;
    localparam int INC_W       = MUL_W - INTEG_SHIFT;
    localparam int PROP_TERM_W = MUL_W - PROP_SHIFT;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [STEP_W-1:0] NOMINAL_RESET = 32'd5927193;
    localparam logic [63:0]       HALF_PI_Q30   = 64'd1686629713;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd2;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_DET  = 2'd0,
        MUL_INT  = 2'd1,
        MUL_PROP = 2'd2
    } mul_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_upd;
        logic     err_upd;
        logic     integ_upd;
        logic     step_upd;
        logic     out_load;
    } spll_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } spll_status_t;

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [ROM_SIZE];

    // Quarter-wave table from an eight-term Taylor series in Q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] a;
        logic [63:0] t;
        longint      s;
        longint      v;
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            a = (64'(k) * HALF_PI_Q30) >> SINE_ROM_BITS;
            t = a;
            s = longint'(a);
            for (int n = 1; n <= 7; n++)
            begin
                t = (t * a) >> 30;
                t = (t * a) >> 30;
                case (n)
                    1:       t = t / 6;
                    2:       t = t / 20;
                    3:       t = t / 42;
                    4:       t = t / 72;
                    5:       t = t / 110;
                    6:       t = t / 156;
                    default: t = t / 210;
                endcase
                if ((n % 2) == 1)
                    s = s - longint'(t);
                else
                    s = s + longint'(t);
            end
            if (s < 0)
                s = 0;
            v = longint'((64'(s) * 64'd32767 + 64'd536870912) >> 30);
            if (v > 32767)
                v = 32767;
            rom[k] = SAMPLE_W'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Sine of a phase in turns times 2^32, mirrored and negated by quadrant
    function automatic logic signed [SAMPLE_W-1:0] sine_of(input logic [STEP_W-1:0] p);
        logic [1:0]               quad;
        logic [SINE_ROM_BITS-1:0] idx;
        logic [ROM_ADDR_W-1:0]    addr;
        logic signed [SAMPLE_W-1:0] v;
        quad = p[STEP_W-1 -: 2];
        idx  = p[STEP_W-3 -: SINE_ROM_BITS];
        if (quad[0])
            addr = ROM_ADDR_W'(1 << SINE_ROM_BITS) - {1'b0, idx};
        else
            addr = {1'b0, idx};
        v = SINE_ROM[addr];
        return quad[1] ? -v : v;
    endfunction

endpackage

// ===== rtl/spll_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module spll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/spll_ctrl.sv =====
// Sequencing state machine of the single-phase PLL.
module spll_ctrl
    import spll_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  spll_status_t status,
    output spll_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SUM   = 7'b0000010,
        ST_ERR   = 7'b0000100,
        ST_MULI  = 7'b0001000,
        ST_INTEG = 7'b0010000,
        ST_STEP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode the step of the sequence into datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = MUL_DET;
        cmd.sum_upd   = 1'b0;
        cmd.err_upd   = 1'b0;
        cmd.integ_upd = 1'b0;
        cmd.step_upd  = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_DET;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_upd = 1'b1;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_upd = 1'b1;
                state_next  = ST_MULI;
            end
            ST_MULI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INT;
                state_next  = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.integ_upd = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_PROP;
                state_next    = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step_upd = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/spll_dp.sv =====
// Datapath of the single-phase PLL: detector, moving average, PI loop, phase and sine.
module spll_dp
    import spll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  spll_cmd_t                  cmd,
    output spll_status_t               status,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] sine_out,
    output logic signed [SAMPLE_W-1:0] quadrature_out,
    output logic [STEP_W-1:0]          freq_step
);

    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;
    logic [WIN_SHIFT-1:0]       ptr_reg;
    logic                       filled_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [MUL_W-1:0]    mult_reg;
    logic [STEP_W-1:0]          integ_reg;
    logic [STEP_W-1:0]          integ_next;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic [STEP_W-1:0]          phase_reg;
    logic [STEP_W-1:0]          phase_next;
    logic signed [SAMPLE_W-1:0] last_quad_reg;
    logic signed [SAMPLE_W-1:0] sine_next;
    logic signed [SAMPLE_W-1:0] cos_next;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sine_reg;
    logic signed [SAMPLE_W-1:0] quad_reg;
    logic [STEP_W-1:0]          freq_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   old_prod;
    logic [PROD_W-1:0]          ram_rdata;
    logic [SUM_W-1:0]           sum_mag;
    logic [PROD_W-1:0]          avg_mag;
    logic signed [INC_W-1:0]    integ_inc;
    logic signed [PROP_TERM_W-1:0] prop_term;
    logic signed [STEP_EXT_W-1:0]  integ_sum;
    logic signed [STEP_EXT_W-1:0]  step_sum;

    // Window store of past detector products
    spll_ram #(
        .WIDTH (PROD_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .we    (cmd.sum_upd),
        .waddr (ptr_reg),
        .wdata (prod),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Select operands of the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_INT:
            begin
                mul_a = err_reg;
                mul_b = {1'b0, integ_gain_reg};
            end
            MUL_PROP:
            begin
                mul_a = err_reg;
                mul_b = {1'b0, prop_gain_reg};
            end
            default:
            begin
                mul_a = {{(MUL_A_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                mul_b = {{(MUL_B_W-SAMPLE_W){last_quad_reg[SAMPLE_W-1]}}, last_quad_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            mult_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // Slide the window: add the new product, drop the oldest one
    assign prod     = mult_reg[PROD_W-1:0];
    assign old_prod = filled_reg ? $signed(ram_rdata) : '0;
    assign sum_next = sum_reg
                    + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod}
                    - {{(SUM_W-PROD_W){old_prod[PROD_W-1]}}, old_prod};

    // Negated average, truncated toward zero
    assign sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign avg_mag  = sum_mag[SUM_W-1:WIN_SHIFT];
    assign err_next = sum_reg[SUM_W-1] ? $signed({1'b0, avg_mag})
                                       : -$signed({1'b0, avg_mag});

    // Integrator update with saturation to the step range
    assign integ_inc = mult_reg[MUL_W-1:INTEG_SHIFT];
    assign integ_sum = $signed({2'b00, integ_reg})
                     + {{(STEP_EXT_W-INC_W){integ_inc[INC_W-1]}}, integ_inc};
    always_comb
    begin
        if (integ_sum[STEP_EXT_W-1])
            integ_next = '0;
        else if (integ_sum[STEP_W])
            integ_next = '1;
        else
            integ_next = integ_sum[STEP_W-1:0];
    end

    // Frequency step: integrator plus proportional term, saturated
    assign prop_term = mult_reg[MUL_W-1:PROP_SHIFT];
    assign step_sum  = $signed({2'b00, integ_reg})
                     + {{(STEP_EXT_W-PROP_TERM_W){prop_term[PROP_TERM_W-1]}}, prop_term};
    always_comb
    begin
        if (step_sum[STEP_EXT_W-1])
            step_next = '0;
        else if (step_sum[STEP_W])
            step_next = '1;
        else
            step_next = step_sum[STEP_W-1:0];
    end

    // Advance the phase and look up sine and cosine
    assign phase_next = phase_reg + step_reg;
    assign sine_next  = sine_of(phase_next);
    assign cos_next   = sine_of(phase_next + STEP_W'(1 << 30));

    // Window pointer, fill flag and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            filled_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else if (cmd.sum_upd)
        begin
            sum_reg <= sum_next;
            if (ptr_reg == WIN_SHIFT'(WINDOW_LEN - 1))
            begin
                ptr_reg    <= '0;
                filled_reg <= 1'b1;
            end
            else
                ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // Gains and integrator: configuration writes, else the integrator's loop update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            integ_reg      <= NOMINAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NOMINAL_STEP: integ_reg      <= cfg_data[STEP_W-1:0];
                REG_PROP_GAIN:    prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:   integ_gain_reg <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
        else if (cmd.integ_upd)
            integ_reg <= integ_next;
    end

    // Phase accumulator and fed-back quadrature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            last_quad_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            phase_reg     <= phase_next;
            last_quad_reg <= cos_next;
        end
    end

    // Intermediate payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.err_upd)
            err_reg <= err_next;
        if (cmd.step_upd)
            step_reg <= step_next;
        if (cmd.out_load)
        begin
            sine_reg <= sine_next;
            quad_reg <= cos_next;
            freq_reg <= step_reg;
        end
    end

    // Output valid: set on load, drop once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign sine_out        = sine_reg;
    assign quadrature_out  = quad_reg;
    assign freq_step       = freq_reg;

endmodule

// ===== rtl/single_phase_pll_moving_average_unit.sv =====
// Top level of the single-phase PLL with moving-average product detector.
//
// One voltage sample (signed Q1.15) enters per transaction on the s_axis
// channel. Each sample is multiplied by the previous cosine output, the
// product is averaged over a 1024-entry sliding window, and a PI loop turns
// the negated average into a frequency step that drives a 32-bit phase
// accumulator. Each sample gives one result on m_axis: sine, cosine and the
// step used. The cfg port writes nominal step (also reloads the integrator),
// proportional gain and integral gain; the user must write them while the block is idle.
//
// A sample is taken only in the idle state; the controller then steps through
// SUM, ERR, MULI, INTEG, STEP and OUT, using one shared multiplier three times
// and one window-RAM read and write. The block has no check of its own on cfg.
// A new sample may be taken while the previous result still waits on m_axis;
// if the receiver stalls, the block holds its finished result in the final
// step and takes no further sample until the output register is free.
// Reset clears the window (through a fill flag, no clearing pass), the sum,
// phase and gains, and loads the integrator with the nominal step.
module single_phase_pll_moving_average_unit
    import spll_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [15:0] sine_out, [31:16] quadrature_out,
                                                 // [63:32] freq_step
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    spll_cmd_t                  cmd;
    spll_status_t               status;
    logic signed [SAMPLE_W-1:0] sine_out;
    logic signed [SAMPLE_W-1:0] quadrature_out;
    logic [STEP_W-1:0]          freq_step;

    spll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spll_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .sine_out       (sine_out),
        .quadrature_out (quadrature_out),
        .freq_step      (freq_step)
    );

    // Pack the result fields, sine_out in the lowest bits
    assign m_axis_tdata = {freq_step, quadrature_out, sine_out};

endmodule
